### rtl/core/uas_pkg.sv
// ----------------------------------------------------------------------------
// uas_pkg
// shared codes and field widths of the undirected adjacency store
// ----------------------------------------------------------------------------
package uas_pkg;

  localparam int NODE_W   = 4;   // node number field
  localparam int NCNT_W   = 5;   // node_count register
  localparam int DEGF_W   = 4;   // degree fields of a result
  localparam int EDGE_W   = 7;   // edge count field
  localparam int STAT_W   = 2;
  localparam int ACT_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [EDGE_W-1:0] EDGE_MAX = 7'd127;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

### rtl/core/uas_ram.sv
// ----------------------------------------------------------------------------
// uas_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module uas_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/undirected_adjacency_store_unit.sv
// ----------------------------------------------------------------------------
// undirected_adjacency_store_unit
// undirected graph kept as bounded per-node neighbor lists in ram
// ----------------------------------------------------------------------------
// Each input item adds, removes or queries one edge and yields exactly one
// result item with status, presence, both degrees, the maximum degree over
// the nodes in use and the edge count. Items are handled one at a time by a
// sequencer around two rams: the neighbor-slot ram and the degree ram (with
// per-node valid bits, so degrees read as zero after reset without a clearing
// pass). An item is accepted, its two degrees are fetched and a decision is
// made; then come either the slot and degree writes of an accepted add, or a
// list walk over node_a's list for a query, a refused add or a remove,
// followed by a second walk over node_b's list for a remove of a present
// edge between two different nodes; then a maximum-degree sweep through the
// degree ram read port, and the output. An out-of-range node goes straight
// to the sweep. The output side can hold off the result. A new item is
// taken while the previous result still waits in the output register.
module undirected_adjacency_store_unit #(
  parameter int NODES   = 16,
  parameter int MAX_DEG = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config: node_count
  input  logic                               cfg_we_i,
  input  logic [uas_pkg::NCNT_W-1:0]         cfg_wdata_i,
  // input items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] action, [5:2] node_a, [9:6] node_b, rest zero
  input  logic [uas_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [1:0] status, [2] edge_present, [6:3] degree_a, [10:7] degree_b,
  // [14:11] max_degree, [21:15] edge_count, rest zero
  output logic [uas_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  // only node numbers that fit the node field can ever be addressed
  localparam int USED     = (NODES < 16) ? NODES : 16;
  localparam int NIW      = $clog2(USED);
  localparam int DW       = $clog2(MAX_DEG + 1);
  localparam int NB_DEPTH = USED * MAX_DEG;
  localparam int NAW      = $clog2(NB_DEPTH);
  localparam int CW       = $clog2(USED + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAPA   = 4'd1;
  localparam logic [3:0] S_CAPB   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_ADD2   = 4'd4;
  localparam logic [3:0] S_ADD3   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_MAX    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // slot address of a node's list entry
  function automatic logic [NAW-1:0] nb_addr(input logic [NIW-1:0] node,
                                            input logic [DW-1:0]  slot);
    return NAW'(node) * NAW'(MAX_DEG) + NAW'(slot);
  endfunction

  // control registers
  logic [3:0]                   state_q, state_d;
  logic [uas_pkg::NCNT_W-1:0]   nc_q, nc_d;
  logic [uas_pkg::EDGE_W-1:0]   edges_q, edges_d;
  logic [USED-1:0]              valid_q, valid_d;
  logic                         vrd_q;
  logic                         pend_q, pend_d;
  logic                         mpend_q, mpend_d;
  logic                         ovalid_q, ovalid_d;

  // item and working registers
  logic [uas_pkg::ACT_W-1:0]    act_q, act_d;
  logic [uas_pkg::NODE_W-1:0]   a_q, a_d, b_q, b_d;
  logic [DW-1:0]                da_q, da_d, db_q, db_d;
  logic [uas_pkg::STAT_W-1:0]   st_q, st_d;
  logic                         pres_q, pres_d;
  logic [DW-1:0]                rda_q, rda_d, rdb_q, rdb_d, mx_q, mx_d;
  logic [NIW-1:0]               node_q, node_d;
  logic [uas_pkg::NODE_W-1:0]   tgt_q, tgt_d;
  logic [DW-1:0]                len_q, len_d, idx_q, idx_d;
  logic [DW-1:0]                keep_q, keep_d, hits_q, hits_d;
  logic                         compact_q, compact_d, phase_b_q, phase_b_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [uas_pkg::OUT_TDATA_W-1:0] odata_q, odata_d;

  // ram ports
  logic                         nb_we;
  logic [NAW-1:0]               nb_waddr, nb_raddr;
  logic [uas_pkg::NODE_W-1:0]   nb_wdata, nb_rdata;
  logic                         deg_we;
  logic [NIW-1:0]               deg_waddr, deg_raddr;
  logic [DW-1:0]                deg_wdata, deg_rdata, deg_rd;

  // input fields
  logic [uas_pkg::ACT_W-1:0]    in_act;
  logic [uas_pkg::NODE_W-1:0]   in_a, in_b;
  logic                         in_accept;

  // helpers
  logic [uas_pkg::NCNT_W-1:0]   eff;
  logic                         same;
  logic [DW-1:0]                new_da, new_db, gone;
  logic                         full;
  logic                         issue, missue;

  assign in_act    = s_axis_tdata_i[1:0];
  assign in_a      = s_axis_tdata_i[5:2];
  assign in_b      = s_axis_tdata_i[9:6];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // effective node count: zero acts as one, clipped to the node range
  always_comb begin
    if (nc_q == '0) begin
      eff = uas_pkg::NCNT_W'(1);
    end else if (nc_q > uas_pkg::NCNT_W'(USED)) begin
      eff = uas_pkg::NCNT_W'(USED);
    end else begin
      eff = nc_q;
    end
  end

  // never-written degree entries read as zero
  assign deg_rd = vrd_q ? deg_rdata : '0;

  assign same   = (a_q == b_q);
  assign new_da = same ? (da_q + DW'(2)) : (da_q + DW'(1));
  assign new_db = same ? (da_q + DW'(2)) : (db_q + DW'(1));
  // a self-loop needs two free slots in the one list
  assign full   = same ? ((int'(da_q) + 2) > MAX_DEG)
                       : ((int'(da_q) >= MAX_DEG) || (int'(db_q) >= MAX_DEG));
  assign gone   = same ? (hits_q >> 1) : hits_q;

  assign issue  = (idx_q < len_q);
  assign missue = (uas_pkg::NCNT_W'(cnt_q) < eff);

  always_comb begin
    state_d   = state_q;
    nc_d      = cfg_we_i ? cfg_wdata_i : nc_q;
    edges_d   = edges_q;
    pend_d    = pend_q;
    mpend_d   = mpend_q;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    act_d     = act_q;
    a_d       = a_q;
    b_d       = b_q;
    da_d      = da_q;
    db_d      = db_q;
    st_d      = st_q;
    pres_d    = pres_q;
    rda_d     = rda_q;
    rdb_d     = rdb_q;
    mx_d      = mx_q;
    node_d    = node_q;
    tgt_d     = tgt_q;
    len_d     = len_q;
    idx_d     = idx_q;
    keep_d    = keep_q;
    hits_d    = hits_q;
    compact_d = compact_q;
    phase_b_d = phase_b_q;
    cnt_d     = cnt_q;
    odata_d   = odata_q;

    nb_we     = 1'b0;
    nb_waddr  = nb_addr(node_q, keep_q);
    nb_wdata  = nb_rdata;
    nb_raddr  = nb_addr(node_q, idx_q);
    deg_we    = 1'b0;
    deg_waddr = a_q[NIW-1:0];
    deg_wdata = keep_q;
    deg_raddr = b_q[NIW-1:0];

    unique case (state_q)
      S_IDLE: begin
        deg_raddr = in_a[NIW-1:0];
        if (in_accept) begin
          act_d   = in_act;
          a_d     = in_a;
          b_d     = in_b;
          cnt_d   = '0;
          mpend_d = 1'b0;
          mx_d    = '0;
          if ((uas_pkg::NCNT_W'(in_a) >= eff) || (uas_pkg::NCNT_W'(in_b) >= eff)) begin
            // out-of-range node: nothing changes, presence and degree fields zero
            st_d    = uas_pkg::ST_RANGE;
            pres_d  = 1'b0;
            rda_d   = '0;
            rdb_d   = '0;
            state_d = S_MAX;
          end else begin
            state_d = S_CAPA;
          end
        end
      end

      S_CAPA: begin
        da_d      = deg_rd;
        deg_raddr = b_q[NIW-1:0];
        state_d   = S_CAPB;
      end

      S_CAPB: begin
        db_d    = deg_rd;
        state_d = S_DECIDE;
      end

      S_DECIDE: begin
        // list walk setup, node_a's list looking for node_b
        node_d    = a_q[NIW-1:0];
        tgt_d     = b_q;
        len_d     = da_q;
        idx_d     = '0;
        keep_d    = '0;
        hits_d    = '0;
        pend_d    = 1'b0;
        phase_b_d = 1'b0;
        compact_d = 1'b0;
        st_d      = uas_pkg::ST_OK;
        unique case (act_q)
          uas_pkg::ACT_ADD: begin
            if (full) begin
              st_d    = uas_pkg::ST_FULL;
              state_d = S_SCAN;
            end else begin
              nb_we    = 1'b1;
              nb_waddr = nb_addr(a_q[NIW-1:0], da_q);
              nb_wdata = b_q;
              state_d  = S_ADD2;
            end
          end
          uas_pkg::ACT_REMOVE: begin
            compact_d = 1'b1;
            state_d   = S_SCAN;
          end
          default: begin
            // query, and the unused action code
            state_d = S_SCAN;
          end
        endcase
      end

      S_ADD2: begin
        nb_we     = 1'b1;
        nb_waddr  = nb_addr(b_q[NIW-1:0], same ? (da_q + DW'(1)) : db_q);
        nb_wdata  = a_q;
        deg_we    = 1'b1;
        deg_waddr = a_q[NIW-1:0];
        deg_wdata = new_da;
        state_d   = S_ADD3;
      end

      S_ADD3: begin
        // for a self-loop this rewrites the same degree
        deg_we    = 1'b1;
        deg_waddr = b_q[NIW-1:0];
        deg_wdata = new_db;
        if (edges_q != uas_pkg::EDGE_MAX) begin
          edges_d = edges_q + uas_pkg::EDGE_W'(1);
        end
        pres_d  = 1'b1;
        rda_d   = new_da;
        rdb_d   = new_db;
        state_d = S_MAX;
      end

      S_SCAN: begin
        // one slot read issued per cycle, its data back in the next cycle
        if (issue) begin
          idx_d = idx_q + DW'(1);
        end
        pend_d = issue;
        if (pend_q) begin
          if (nb_rdata == tgt_q) begin
            hits_d = hits_q + DW'(1);
          end else if (compact_q) begin
            // survivors move down in order; write slot trails the read slot
            nb_we    = 1'b1;
            nb_waddr = nb_addr(node_q, keep_q);
            nb_wdata = nb_rdata;
            keep_d   = keep_q + DW'(1);
          end
        end
        if (!issue && !pend_q) begin
          if (!compact_q) begin
            pres_d  = (hits_q != '0);
            rda_d   = da_q;
            rdb_d   = db_q;
            state_d = S_MAX;
          end else if (phase_b_q) begin
            deg_we    = 1'b1;
            deg_waddr = b_q[NIW-1:0];
            deg_wdata = keep_q;
            rdb_d     = keep_q;
            pres_d    = 1'b0;
            state_d   = S_MAX;
          end else if (hits_q == '0) begin
            // edge missing: walk rewrote every slot with its own value
            st_d    = uas_pkg::ST_NOT_FOUND;
            pres_d  = 1'b0;
            rda_d   = da_q;
            rdb_d   = db_q;
            state_d = S_MAX;
          end else begin
            deg_we    = 1'b1;
            deg_waddr = a_q[NIW-1:0];
            deg_wdata = keep_q;
            rda_d     = keep_q;
            pres_d    = 1'b0;
            if (edges_q > uas_pkg::EDGE_W'(gone)) begin
              edges_d = edges_q - uas_pkg::EDGE_W'(gone);
            end else begin
              edges_d = '0;
            end
            if (same) begin
              rdb_d   = keep_q;
              state_d = S_MAX;
            end else begin
              // second pass over node_b's list dropping node_a
              node_d    = b_q[NIW-1:0];
              tgt_d     = a_q;
              len_d     = db_q;
              idx_d     = '0;
              keep_d    = '0;
              hits_d    = '0;
              pend_d    = 1'b0;
              phase_b_d = 1'b1;
            end
          end
        end
      end

      S_MAX: begin
        // sweep of degrees over the nodes in use
        deg_raddr = cnt_q[NIW-1:0];
        if (missue) begin
          cnt_d = cnt_q + CW'(1);
        end
        mpend_d = missue;
        if (mpend_q && (deg_rd > mx_q)) begin
          mx_d = deg_rd;
        end
        if (!missue && !mpend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = {2'b00, edges_q, uas_pkg::DEGF_W'(mx_q), uas_pkg::DEGF_W'(rdb_q),
                      uas_pkg::DEGF_W'(rda_q), pres_q, st_q};
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (deg_we) begin
      valid_d[deg_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nc_q     <= uas_pkg::NCNT_W'(16);
      edges_q  <= '0;
      valid_q  <= '0;
      vrd_q    <= 1'b0;
      pend_q   <= 1'b0;
      mpend_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nc_q     <= nc_d;
      edges_q  <= edges_d;
      valid_q  <= valid_d;
      vrd_q    <= valid_q[deg_raddr];
      pend_q   <= pend_d;
      mpend_q  <= mpend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    a_q       <= a_d;
    b_q       <= b_d;
    da_q      <= da_d;
    db_q      <= db_d;
    st_q      <= st_d;
    pres_q    <= pres_d;
    rda_q     <= rda_d;
    rdb_q     <= rdb_d;
    mx_q      <= mx_d;
    node_q    <= node_d;
    tgt_q     <= tgt_d;
    len_q     <= len_d;
    idx_q     <= idx_d;
    keep_q    <= keep_d;
    hits_q    <= hits_d;
    compact_q <= compact_d;
    phase_b_q <= phase_b_d;
    cnt_q     <= cnt_d;
    odata_q   <= odata_d;
  end

  // neighbor slots, MAX_DEG per node
  uas_ram #(
    .WIDTH (uas_pkg::NODE_W),
    .DEPTH (NB_DEPTH)
  ) u_nb_ram (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (nb_waddr),
    .wdata_i (nb_wdata),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rdata)
  );

  // list length per node
  uas_ram #(
    .WIDTH (DW),
    .DEPTH (USED)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

endmodule

### verif/uas_graph_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uas_graph_checker
// watches both item channels and the node_count port of the adjacency store,
// keeps its own copy of the graph, and checks every result field by field
// ----------------------------------------------------------------------------
module uas_graph_checker #(
  parameter int NODES   = 16,
  parameter int MAX_DEG = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uas_pkg::NCNT_W-1:0]     cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // [1:0] action, [5:2] node_a, [9:6] node_b
  input  logic [uas_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // [1:0] status, [2] edge_present, [6:3] degree_a, [10:7] degree_b,
  // [14:11] max_degree, [21:15] edge_count
  input  logic [uas_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             full_hits_o,
  output int                             missing_hits_o,
  output int                             range_hits_o
);

  typedef struct packed {
    logic [uas_pkg::STAT_W-1:0] status;
    logic                       present;
    logic [uas_pkg::DEGF_W-1:0] deg_a;
    logic [uas_pkg::DEGF_W-1:0] deg_b;
    logic [uas_pkg::DEGF_W-1:0] max_deg;
    logic [uas_pkg::EDGE_W-1:0] edges;
  } graph_result_t;

  graph_result_t              graph_results_q[$];
  logic [uas_pkg::NODE_W-1:0] slot_mem [NODES][MAX_DEG];
  int unsigned                node_deg [NODES];
  int unsigned                edge_tally;
  logic [uas_pkg::NCNT_W-1:0] node_count_q;
  int                         mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic bit has_neighbor(int unsigned x, int unsigned y);
    for (int i = 0; i < node_deg[x]; i++)
      if (slot_mem[x][i] == y) return 1'b1;
    return 1'b0;
  endfunction

  // drop every y from x's list, survivors keep their order
  function automatic int unsigned strip_neighbor(int unsigned x, int unsigned y);
    int unsigned keep;
    int unsigned n;
    keep = 0;
    n    = node_deg[x];
    for (int i = 0; i < n; i++) begin
      if (slot_mem[x][i] != y) begin
        slot_mem[x][keep] = slot_mem[x][i];
        keep++;
      end
    end
    node_deg[x] = keep;
    return n - keep;
  endfunction

  function automatic graph_result_t predict_graph_step(
      logic [uas_pkg::ACT_W-1:0] act,
      logic [uas_pkg::NODE_W-1:0] a_n,
      logic [uas_pkg::NODE_W-1:0] b_n);
    graph_result_t r;
    int unsigned   lim;
    int unsigned   a;
    int unsigned   b;
    int unsigned   gone;
    bit            full;
    r = '0;
    a = 32'(a_n);
    b = 32'(b_n);
    // zero acts as one node, anything past NODES as NODES
    if (node_count_q == 0) lim = 1;
    else if (node_count_q > NODES) lim = NODES;
    else lim = 32'(node_count_q);
    if (a >= lim || b >= lim) begin
      r.status = uas_pkg::ST_RANGE;
    end else begin
      r.status = uas_pkg::ST_OK;
      case (act)
        uas_pkg::ACT_ADD: begin
          // a self-loop needs two free slots in the one list
          if (a == b) full = (node_deg[a] + 2 > MAX_DEG);
          else full = (node_deg[a] >= MAX_DEG) || (node_deg[b] >= MAX_DEG);
          if (full) begin
            r.status = uas_pkg::ST_FULL;
          end else begin
            slot_mem[a][node_deg[a]] = uas_pkg::NODE_W'(b);
            node_deg[a]++;
            slot_mem[b][node_deg[b]] = uas_pkg::NODE_W'(a);
            node_deg[b]++;
            if (edge_tally < uas_pkg::EDGE_MAX) edge_tally++;
          end
        end
        uas_pkg::ACT_REMOVE: begin
          if (!has_neighbor(a, b)) begin
            r.status = uas_pkg::ST_NOT_FOUND;
          end else begin
            gone = strip_neighbor(a, b);
            if (a == b) gone = gone / 2;
            else void'(strip_neighbor(b, a));
            edge_tally = (edge_tally > gone) ? edge_tally - gone : 0;
          end
        end
        default: begin
          // query, and the spare code reads as one too
        end
      endcase
      r.present = has_neighbor(a, b);
      r.deg_a   = uas_pkg::DEGF_W'(node_deg[a]);
      r.deg_b   = uas_pkg::DEGF_W'(node_deg[b]);
    end
    for (int i = 0; i < lim; i++)
      if (node_deg[i] > r.max_deg) r.max_deg = uas_pkg::DEGF_W'(node_deg[i]);
    r.edges = uas_pkg::EDGE_W'(edge_tally);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    graph_result_t got;
    graph_result_t want;
    graph_result_t pred;
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) begin
        node_deg[n] = 0;
        for (int s = 0; s < MAX_DEG; s++) slot_mem[n][s] = '0;
      end
      edge_tally   = 0;
      node_count_q = uas_pkg::NCNT_W'(16);
      graph_results_q.delete();
      pending_o      <= 0;
      checked_o      <= 0;
      full_hits_o    <= 0;
      missing_hits_o <= 0;
      range_hits_o   <= 0;
    end else begin
      if (cfg_we_i) node_count_q = cfg_wdata_i;
      // results first, so an item taken at the same edge is not matched
      if (m_tvalid_i && m_tready_i) begin
        got.status  = m_tdata_i[1:0];
        got.present = m_tdata_i[2];
        got.deg_a   = m_tdata_i[6:3];
        got.deg_b   = m_tdata_i[10:7];
        got.max_deg = m_tdata_i[14:11];
        got.edges   = m_tdata_i[21:15];
        if (graph_results_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = graph_results_q.pop_front();
          check_field("status", 8'(got.status), 8'(want.status));
          check_field("edge_present", 8'(got.present), 8'(want.present));
          check_field("degree_a", 8'(got.deg_a), 8'(want.deg_a));
          check_field("degree_b", 8'(got.deg_b), 8'(want.deg_b));
          check_field("max_degree", 8'(got.max_deg), 8'(want.max_deg));
          check_field("edge_count", 8'(got.edges), 8'(want.edges));
          checked_o <= checked_o + 1;
          if (want.status == uas_pkg::ST_FULL) full_hits_o <= full_hits_o + 1;
          if (want.status == uas_pkg::ST_NOT_FOUND) missing_hits_o <= missing_hits_o + 1;
          if (want.status == uas_pkg::ST_RANGE) range_hits_o <= range_hits_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pred = predict_graph_step(s_tdata_i[1:0], s_tdata_i[5:2], s_tdata_i[9:6]);
        graph_results_q = {graph_results_q, pred};
      end
      pending_o <= graph_results_q.size();
    end
  end

endmodule

### verif/undirected_adjacency_store_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// undirected_adjacency_store_unit_tb
// drives edge add, remove and query items into the adjacency store under
// several node counts, with random gaps on both sides and one long output
// stall; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module undirected_adjacency_store_unit_tb;

  localparam int NODES        = 16;
  localparam int MAX_DEG      = 8;
  localparam int IDLE_PCT     = 31;   // chance of a gap per item / per cycle
  localparam int STALL_CYCLES = 400;  // long output hold-off
  localparam int DRAIN_CYCLES = 64;   // well past the slowest item
  // spare action code, the block reads it as a query
  localparam logic [uas_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [uas_pkg::NCNT_W-1:0]      cfg_wdata = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [uas_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [uas_pkg::OUT_TDATA_W-1:0] m_tdata;

  int fails;
  int pending;
  int checked;
  int full_hits;
  int missing_hits;
  int range_hits;

  bit          idle_on     = 1'b1;  // random gaps on both sides
  bit          stall_req   = 1'b0;  // asks the receiver for one long hold-off
  int          items_sent  = 0;
  int          node_limit  = NODES; // node count as the block applies it
  logic [7:0]  recent_edges[$];     // {node_b, node_a} of recent adds

  // 4 ns clock
  always #2 clk = ~clk;

  undirected_adjacency_store_unit #(
    .NODES   (NODES),
    .MAX_DEG (MAX_DEG)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  uas_graph_checker #(
    .NODES   (NODES),
    .MAX_DEG (MAX_DEG)
  ) graph_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_hits_o    (full_hits),
    .missing_hits_o (missing_hits),
    .range_hits_o   (range_hits)
  );

  // result side: random back-pressure, or one long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (stall_req) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        m_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  // one item, with an optional gap in front; valid is only lowered in a gap
  task automatic send_item(input logic [uas_pkg::ACT_W-1:0] act,
                           input logic [uas_pkg::NODE_W-1:0] a,
                           input logic [uas_pkg::NODE_W-1:0] b);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(uas_pkg::IN_TDATA_W - 2 * uas_pkg::NODE_W - uas_pkg::ACT_W){1'b0}},
                 b, a, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // node_count is only written once every result is back
  task automatic set_node_count(input logic [uas_pkg::NCNT_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (value == 0) node_limit = 1;
    else if (value > NODES) node_limit = NODES;
    else node_limit = int'(value);
  endtask

  // mostly well-formed graph traffic: adds, removes of recently added
  // edges, queries; about one item in ten is unconstrained noise
  task automatic random_item();
    int                         pick;
    logic [uas_pkg::ACT_W-1:0]  act;
    logic [uas_pkg::NODE_W-1:0] a;
    logic [uas_pkg::NODE_W-1:0] b;
    logic [7:0]                 e;
    pick = $urandom_range(99);
    a    = uas_pkg::NODE_W'($urandom_range(node_limit - 1));
    b    = uas_pkg::NODE_W'($urandom_range(node_limit - 1));
    act  = uas_pkg::ACT_QUERY;
    if (pick < 45) begin
      act = uas_pkg::ACT_ADD;
      recent_edges = {recent_edges, {b, a}};
      if (recent_edges.size() > 24) void'(recent_edges.pop_front());
    end else if (pick < 75) begin
      act = uas_pkg::ACT_REMOVE;
      if (recent_edges.size() > 0) begin
        e = recent_edges[$urandom_range(recent_edges.size() - 1)];
        if ($urandom_range(1)) {b, a} = e;
        else {a, b} = e;
      end
    end else if (pick < 90) begin
      act = ($urandom_range(3) == 0) ? ACT_SPARE : uas_pkg::ACT_QUERY;
    end else begin
      act = uas_pkg::ACT_W'($urandom_range(3));
      a   = uas_pkg::NODE_W'($urandom_range(15));
      b   = uas_pkg::NODE_W'($urandom_range(15));
    end
    send_item(act, a, b);
  endtask

  task automatic run_phase(input logic [uas_pkg::NCNT_W-1:0] value, input int count);
    set_node_count(value);
    repeat (count) random_item();
  endtask

  initial begin : stimulus
    logic [uas_pkg::NCNT_W-1:0] mid_count;
    mid_count = uas_pkg::NCNT_W'($urandom_range(2, 15));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset node count of 16
    send_item(uas_pkg::ACT_QUERY, 0, 0);    // empty graph
    send_item(uas_pkg::ACT_ADD, 0, 15);     // lowest and highest node numbers
    send_item(uas_pkg::ACT_ADD, 15, 0);     // same edge again, duplicates allowed
    send_item(uas_pkg::ACT_ADD, 3, 3);      // self-loop takes two slots
    send_item(ACT_SPARE, 3, 3);             // spare action code acts as a query
    send_item(uas_pkg::ACT_REMOVE, 3, 3);   // self-loop gone, count drops by one
    send_item(uas_pkg::ACT_REMOVE, 3, 3);   // now missing
    send_item(uas_pkg::ACT_REMOVE, 0, 15);  // both duplicates go in one remove
    send_item(uas_pkg::ACT_REMOVE, 15, 0);  // missing from either side
    for (int k = 6; k < 14; k++)
      send_item(uas_pkg::ACT_ADD, 5, uas_pkg::NODE_W'(k));  // fill node 5 to the limit
    send_item(uas_pkg::ACT_ADD, 14, 5);     // refused, node 5 full on the far side
    for (int k = 0; k < 3; k++)
      send_item(uas_pkg::ACT_ADD, 6, 6);    // node 6 up to one free slot
    send_item(uas_pkg::ACT_ADD, 6, 6);      // self-loop refused with one slot left
    send_item(uas_pkg::ACT_REMOVE, 5, 9);   // compaction out of a full list
    send_item(uas_pkg::ACT_QUERY, 5, 13);   // tail entry survived the shift

    // fewer nodes: out-of-range endpoints, stale nodes above the count
    set_node_count(5'd4);
    send_item(uas_pkg::ACT_ADD, 4, 0);
    send_item(uas_pkg::ACT_QUERY, 0, 15);
    repeat (100) random_item();

    run_phase(5'd0, 60);                // acts as one node
    run_phase(5'd1, 40);
    run_phase(5'd31, 150);              // clamps to all nodes
    run_phase(5'd17, 100);

    // output held off while items keep coming, so the input side backs up
    set_node_count(5'd16);
    idle_on   = 1'b0;
    stall_req = 1'b1;
    repeat (30) random_item();
    idle_on = 1'b1;

    run_phase(mid_count, 150);
    // a long stretch with no gaps on either side
    set_node_count(5'd16);
    idle_on = 1'b0;
    repeat (150) random_item();
    idle_on = 1'b1;
    run_phase(5'd9, 100);

    // drain
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items over node counts 0, 1, 4, 9, 16, 17, 31 and %0d, %0d results",
             items_sent, mid_count, checked);
    $display("run: %0d list full, %0d edge missing, %0d out of range, one %0d-cycle stall",
             full_hits, missing_hits, range_hits, STALL_CYCLES);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard limit, far past the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
